### rtl/core/efs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Earliest-free-server assigner package
// Shared widths, register indexes, reset values and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package efs_pkg;

  localparam int SERVERS_DEF = 16;

  localparam int TIME_W    = 32;
  localparam int DUR_W     = 16;
  localparam int CNT_W     = 16;
  localparam int IDX_W     = 4;
  localparam int NUM_W     = 5;
  localparam int LIMIT_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SERVERS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_LIMIT  = 1'b1;

  localparam logic [NUM_W-1:0]   NUM_SERVERS_RST = 5'd1;
  localparam logic [LIMIT_W-1:0] WAIT_LIMIT_RST  = 16'd20;

  typedef struct packed {
    logic capture;
    logic rd_en;
    logic calc;
    logic commit;
  } efs_cmd_t;

  typedef struct packed {
    logic rd_last;
    logic out_free;
  } efs_sts_t;

endpackage

### rtl/core/efs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module efs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/efs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Earliest-free-server datapath
// Configuration registers, the server free-time memory with its valid bits,
// the minimum scan, the start and wait computation and the result register.
// ----------------------------------------------------------------------------
module efs_datapath
  import efs_pkg::*;
#(
  parameter int SERVERS = SERVERS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 new_run,
  input  logic [TIME_W-1:0]    arrival_time,
  input  logic [DUR_W-1:0]     job_duration,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [IDX_W-1:0]     server_index,
  output logic [TIME_W-1:0]    start_time,
  output logic                 long_wait,
  output logic [CNT_W-1:0]     long_wait_count,
  input  efs_cmd_t             cmd,
  output efs_sts_t             sts
);

  localparam int IW = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int NW = ($clog2(SERVERS + 1) > NUM_W) ? $clog2(SERVERS + 1) : NUM_W;

  logic [NUM_W-1:0]   num_servers;
  logic [LIMIT_W-1:0] wait_limit;
  logic [TIME_W-1:0]  arrival;
  logic [DUR_W-1:0]   duration;
  logic [CNT_W-1:0]   wait_counter;
  logic [SERVERS-1:0] valid;
  logic [IW-1:0]      rd_idx;
  logic [IW-1:0]      cmp_idx;
  logic               cmp_valid;
  logic               cmp_hit;
  logic [TIME_W-1:0]  best;
  logic [IW-1:0]      best_idx;
  logic [TIME_W-1:0]  start;
  logic [TIME_W-1:0]  rdata;
  logic [TIME_W-1:0]  cand;
  logic [NW-1:0]      num_ext;
  logic [NW-1:0]      active;
  logic [NW-1:0]      last_idx;
  logic [TIME_W-1:0]  wait_time;
  logic               is_long;
  logic [TIME_W:0]    finish_sum;
  logic [TIME_W-1:0]  finish;
  logic [CNT_W-1:0]   counter_next;

  efs_ram #(
    .WIDTH (TIME_W),
    .DEPTH (SERVERS),
    .AW    (IW)
  ) u_free_time (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (best_idx),
    .wdata (finish),
    .re    (cmd.rd_en),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  always_comb begin
    num_ext = NW'(num_servers);
    if (num_ext == '0) begin
      active = NW'(1);
    end else if (num_ext > NW'(SERVERS)) begin
      active = NW'(SERVERS);
    end else begin
      active = num_ext;
    end
    last_idx = active - NW'(1);
    sts.rd_last = (NW'(rd_idx) == last_idx);
    sts.out_free = !out_valid || !out_stall;

    cand = cmp_hit ? rdata : '0;

    wait_time = start - arrival;
    is_long = wait_time > TIME_W'(wait_limit);
    finish_sum = {1'b0, start} + (TIME_W + 1)'(duration);
    finish = finish_sum[TIME_W] ? '1 : finish_sum[TIME_W-1:0];
    counter_next = wait_counter;
    if (is_long && (wait_counter != '1)) begin
      counter_next = wait_counter + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_servers <= NUM_SERVERS_RST;
      wait_limit <= WAIT_LIMIT_RST;
      wait_counter <= '0;
      valid <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_NUM_SERVERS: num_servers <= cfg_data[NUM_W-1:0];
          CFG_WAIT_LIMIT:  wait_limit <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      cmp_valid <= cmd.rd_en;
      if (cmd.capture && new_run) begin
        valid <= '0;
        wait_counter <= '0;
      end
      if (cmd.commit) begin
        valid[best_idx] <= 1'b1;
        wait_counter <= counter_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      arrival <= arrival_time;
      duration <= job_duration;
      rd_idx <= '0;
    end else if (cmd.rd_en) begin
      rd_idx <= rd_idx + IW'(1);
    end
    if (cmd.rd_en) begin
      cmp_idx <= rd_idx;
      cmp_hit <= valid[rd_idx];
    end
    if (cmp_valid && ((cmp_idx == '0) || (cand < best))) begin
      best <= cand;
      best_idx <= cmp_idx;
    end
    if (cmd.calc) begin
      start <= (best > arrival) ? best : arrival;
    end
    if (cmd.commit) begin
      server_index <= IDX_W'(best_idx);
      start_time <= start;
      long_wait <= is_long;
      long_wait_count <= counter_next;
    end
  end

endmodule

### rtl/core/efs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Earliest-free-server controller
// Steps each item through capture, memory scan, start computation and commit.
// ----------------------------------------------------------------------------
module efs_ctrl
  import efs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output efs_cmd_t cmd,
  input  efs_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_CALC,
    S_COMMIT
  } state_t;

  state_t state;

  always_comb begin
    in_stall = (state != S_IDLE);
    cmd.capture = (state == S_IDLE) && in_valid;
    cmd.rd_en = (state == S_SCAN);
    cmd.calc = (state == S_CALC);
    cmd.commit = (state == S_COMMIT) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts.rd_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN:  state <= S_CALC;
        S_CALC:   state <= S_COMMIT;
        S_COMMIT: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/earliest_free_server_assigner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Earliest-free-server assigner
// Assigns each job to the server that frees up first and reports its start.
// ----------------------------------------------------------------------------
// Jobs enter on the input channel (in_valid, in_stall) with new_run,
// arrival_time and job_duration. Each job produces one item on the output
// channel (out_valid, out_stall) carrying server_index, start_time,
// long_wait and long_wait_count. The user writes configuration through
// cfg_write, cfg_index and cfg_data only with no job in flight (unchecked).
// The free times sit in a one-read, one-write memory that is scanned one
// server per cycle. After the scan come a drain step, the start computation
// and the commit; a new job is taken only once the block is back in idle.
// The result register lets the next job be accepted while a result waits;
// that job holds in its commit step until the receiver takes the earlier
// result. Reset clears all free times through the per-server valid bits,
// clears the long-wait count, sets num_servers to 1 and wait_limit to 20,
// and leaves the block ready for its first job in the next cycle.
// ----------------------------------------------------------------------------
module earliest_free_server_assigner
  import efs_pkg::*;
#(
  parameter int SERVERS = SERVERS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 new_run,
  input  logic [TIME_W-1:0]    arrival_time,
  input  logic [DUR_W-1:0]     job_duration,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [IDX_W-1:0]     server_index,
  output logic [TIME_W-1:0]    start_time,
  output logic                 long_wait,
  output logic [CNT_W-1:0]     long_wait_count
);

  efs_cmd_t cmd;
  efs_sts_t sts;

  efs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  efs_datapath #(
    .SERVERS (SERVERS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .new_run         (new_run),
    .arrival_time    (arrival_time),
    .job_duration    (job_duration),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .server_index    (server_index),
    .start_time      (start_time),
    .long_wait       (long_wait),
    .long_wait_count (long_wait_count),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

### tb/earliest_free_server_assigner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Earliest-free-server assigner testbench
// Sends directed and random jobs through the assigner under several server
// counts and wait limits. The bench keeps its own copy of the server free
// times and the long-wait count. From these it predicts the server, start
// time and long-wait status of every job. Each result item is checked field
// by field; in several phases both channels idle and stall at random.
// ----------------------------------------------------------------------------
module earliest_free_server_assigner_tb;
  import efs_pkg::*;

  localparam int MAX_IDLE        = 18;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int STALL_LIMIT     = 4000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int WAIT_JOBS       = 20;

  typedef struct {
    logic              new_run;
    logic [TIME_W-1:0] arrival;
    logic [DUR_W-1:0]  duration;
  } job_t;

  typedef struct {
    logic [IDX_W-1:0]  server;
    logic [TIME_W-1:0] start;
    logic              long_wait;
    logic [CNT_W-1:0]  tally;
  } assignment_t;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = CFG_NUM_SERVERS;
  logic [CFG_W-1:0]     cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic                 new_run      = 1'b0;
  logic [TIME_W-1:0]    arrival_time = '0;
  logic [DUR_W-1:0]     job_duration = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [IDX_W-1:0]     server_index;
  logic [TIME_W-1:0]    start_time;
  logic                 long_wait;
  logic [CNT_W-1:0]     long_wait_count;

  job_t              pending_jobs[$];
  assignment_t       due_assignments[$];
  logic [TIME_W-1:0] free_at [SERVERS_DEF];
  logic [CNT_W-1:0]  long_wait_tally;
  logic [NUM_W-1:0]  model_servers;
  logic [LIMIT_W-1:0] model_limit;

  bit                send_idling  = 1'b0;
  bit                recv_idling  = 1'b0;
  int                send_gap     = 0;
  int                recv_gap     = 0;
  int                hold_req     = 0;
  int                hold_ack     = 0;
  int                hold_left    = 0;
  int                quiet_cycles = 0;
  int                failures     = 0;
  int unsigned       phase_servers = 1;
  logic [TIME_W-1:0] arrival_base = '0;

  earliest_free_server_assigner dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .new_run(new_run),
    .arrival_time(arrival_time),
    .job_duration(job_duration),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .server_index(server_index),
    .start_time(start_time),
    .long_wait(long_wait),
    .long_wait_count(long_wait_count)
  );

  always #2 clk = ~clk;

  function automatic assignment_t assign_job(job_t job);
    assignment_t       res;
    int                active;
    int                pick;
    int                s;
    logic [TIME_W-1:0] wait_span;
    logic [TIME_W:0]   finish;
    if (model_servers == 0) begin
      active = 1;
    end else if (model_servers > SERVERS_DEF) begin
      active = SERVERS_DEF;
    end else begin
      active = model_servers;
    end
    if (job.new_run) begin
      for (s = 0; s < SERVERS_DEF; s++) free_at[s] = '0;
      long_wait_tally = '0;
    end
    pick = 0;
    for (s = 1; s < active; s++) begin
      if (free_at[s] < free_at[pick]) pick = s;
    end
    res.server = pick[IDX_W-1:0];
    res.start = (free_at[pick] > job.arrival) ? free_at[pick] : job.arrival;
    wait_span = res.start - job.arrival;
    res.long_wait = wait_span > model_limit;
    if (res.long_wait && long_wait_tally != '1) long_wait_tally++;
    res.tally = long_wait_tally;
    finish = {1'b0, res.start} + job.duration;
    free_at[pick] = finish[TIME_W] ? '1 : finish[TIME_W-1:0];
    return res;
  endfunction

  // Configuration writes and accepted jobs update the predicted state.
  always @(posedge clk) begin
    job_t taken;
    if (rst) begin
      foreach (free_at[s]) free_at[s] = '0;
      long_wait_tally = '0;
      model_servers = NUM_SERVERS_RST;
      model_limit = WAIT_LIMIT_RST;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_NUM_SERVERS: model_servers = cfg_data[NUM_W-1:0];
          CFG_WAIT_LIMIT: model_limit = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        taken.new_run = new_run;
        taken.arrival = arrival_time;
        taken.duration = job_duration;
        due_assignments.push_back(assign_job(taken));
      end
    end
  end

  always @(posedge clk) begin
    job_t next_job;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_jobs.size() > 0) begin
        next_job = pending_jobs.pop_front();
        new_run <= next_job.new_run;
        arrival_time <= next_job.arrival;
        job_duration <= next_job.duration;
        in_valid <= 1'b1;
        send_gap <= send_idling ? $urandom_range(0, MAX_IDLE) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    int draw;
    if (rst) begin
      out_stall <= 1'b0;
      recv_gap <= 0;
      hold_left <= 0;
      hold_ack <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_OFF_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      draw = recv_idling ? $urandom_range(0, MAX_IDLE) : 0;
      out_stall <= (draw > 0);
      recv_gap <= (draw > 0) ? draw - 1 : 0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    assignment_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_assignments.size() == 0) begin
        $error("Unexpected result item: server_index %0d, start_time %0d",
               server_index, start_time);
        failures++;
      end else begin
        want = due_assignments.pop_front();
        if (server_index !== want.server) begin
          $error("server_index mismatch: expected %0d, actual %0d",
                 want.server, server_index);
          failures++;
        end
        if (start_time !== want.start) begin
          $error("start_time mismatch: expected %0d, actual %0d",
                 want.start, start_time);
          failures++;
        end
        if (long_wait !== want.long_wait) begin
          $error("long_wait mismatch: expected %0d, actual %0d",
                 want.long_wait, long_wait);
          failures++;
        end
        if (long_wait_count !== want.tally) begin
          $error("long_wait_count mismatch: expected %0d, actual %0d",
                 want.tally, long_wait_count);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $error("No item moved for %0d cycles.", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_job(input logic nr, input logic [TIME_W-1:0] arr,
                           input logic [DUR_W-1:0] dur);
    job_t job;
    job.new_run = nr;
    job.arrival = arr;
    job.duration = dur;
    pending_jobs.push_back(job);
  endtask

  task automatic wait_for_drain();
    do @(negedge clk);
    while (pending_jobs.size() != 0 || in_valid || due_assignments.size() != 0);
  endtask

  task automatic reconfigure(input logic [CFG_W-1:0] servers_val,
                             input logic [CFG_W-1:0] limit_val);
    wait_for_drain();
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_NUM_SERVERS;
    cfg_data <= servers_val;
    @(posedge clk);
    cfg_index <= CFG_WAIT_LIMIT;
    cfg_data <= limit_val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (servers_val[NUM_W-1:0] == 0) begin
      phase_servers = 1;
    end else if (servers_val[NUM_W-1:0] > SERVERS_DEF) begin
      phase_servers = SERVERS_DEF;
    end else begin
      phase_servers = servers_val[NUM_W-1:0];
    end
    @(negedge clk);
  endtask

  // Mostly runs of nondecreasing arrivals loaded near capacity, with some
  // jobs of fully random content mixed in.
  task automatic random_jobs(input int count, input int unsigned dur_max);
    int          k;
    int unsigned step_max;
    step_max = dur_max / phase_servers + 1;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 12) begin
        queue_job(1'($urandom_range(0, 1)), $urandom(),
                  DUR_W'($urandom_range(0, 16'hFFFF)));
      end else if ($urandom_range(0, 59) == 0) begin
        arrival_base = ($urandom_range(0, 3) == 0) ?
                       32'hFFFF_FFFF - $urandom_range(0, 200000) :
                       $urandom_range(0, 5000);
        queue_job(1'b1, arrival_base, DUR_W'($urandom_range(0, dur_max)));
      end else begin
        arrival_base += $urandom_range(0, step_max);
        queue_job(1'b0, arrival_base, DUR_W'($urandom_range(0, dur_max)));
      end
    end
  endtask

  initial begin
    int k;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // One server, reset wait limit: long-wait boundary, wrap and saturation.
    queue_job(1'b1, 32'd0, 16'd0);
    queue_job(1'b0, 32'd5, 16'd30);
    queue_job(1'b0, 32'd10, 16'd1);
    queue_job(1'b0, 32'd15, 16'd0);
    queue_job(1'b0, 32'd16, 16'd0);
    queue_job(1'b0, 32'd3, 16'd0);
    queue_job(1'b0, 32'hFFFF_FFF0, 16'hFFFF);
    queue_job(1'b0, 32'hFFFF_FFFF, 16'd0);
    queue_job(1'b0, 32'd0, 16'd0);
    queue_job(1'b1, 32'hFFFF_FFFF, 16'hFFFF);

    // Four servers, zero limit: ties go to the lowest index.
    reconfigure(16'd4, 16'd0);
    queue_job(1'b1, 32'd100, 16'd50);
    queue_job(1'b0, 32'd100, 16'd10);
    queue_job(1'b0, 32'd100, 16'd10);
    queue_job(1'b0, 32'd100, 16'd10);
    queue_job(1'b0, 32'd100, 16'd5);
    queue_job(1'b0, 32'd200, 16'd0);

    // Server count above the array size, widest limit.
    reconfigure(16'd31, 16'hFFFF);
    queue_job(1'b1, 32'd0, 16'hFFFF);
    queue_job(1'b0, 32'hFFFF_FFFF, 16'hFFFF);
    queue_job(1'b0, 32'd0, 16'd0);

    send_idling = 1'b1;
    recv_idling = 1'b1;
    reconfigure(16'd16, 16'd100);
    random_jobs(165, 200);

    send_idling = 1'b0;
    recv_idling = 1'b0;
    reconfigure(16'd2, 16'd5);
    random_jobs(165, 30);

    // The receiver holds off while jobs keep coming, so the input backs up.
    recv_idling = 1'b1;
    reconfigure(16'd31, 16'hFFFF);
    hold_req++;
    random_jobs(165, 16'hFFFF);

    send_idling = 1'b1;
    recv_idling = 1'b0;
    reconfigure(16'd0, 16'd0);
    random_jobs(165, 15);

    recv_idling = 1'b1;
    reconfigure(16'd17, 16'd1000);
    random_jobs(165, 2000);

    reconfigure(16'hFFE5, 16'd40);
    random_jobs(165, 100);

    send_idling = 1'($urandom_range(0, 1));
    recv_idling = 1'($urandom_range(0, 1));
    reconfigure(CFG_W'($urandom_range(0, 16'hFFFF)),
                CFG_W'($urandom_range(0, 16'hFFFF)));
    random_jobs(165, ($urandom_range(0, 1) == 1) ? 300 : 16'hFFFF);

    send_idling = 1'b1;
    recv_idling = 1'b1;
    reconfigure(16'd8, 16'd12);
    random_jobs(165, 50);

    // In the first run each job but the first waits, so the count climbs.
    send_idling = 1'b0;
    recv_idling = 1'b0;
    reconfigure(16'h0020, 16'd0);
    queue_job(1'b1, 32'd0, 16'd1);
    for (k = 0; k < WAIT_JOBS; k++) queue_job(1'b0, 32'd0, 16'd1);
    queue_job(1'b1, 32'd0, 16'd0);
    queue_job(1'b0, 32'd0, 16'd5);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/efs_pkg.sv
rtl/core/efs_ram.sv
rtl/core/efs_datapath.sv
rtl/core/efs_ctrl.sv
rtl/core/earliest_free_server_assigner.sv
tb/earliest_free_server_assigner_tb.sv
